// File: rtl/sdf_pkg.sv
// Shared types and constants for the spring-damper force pipeline.
// No dependencies; imported by every module of the block.
package sdf_pkg;

   // Coordinate format and fixed-point scaling
   localparam int CW   = 32;           // coordinate width
   localparam int FB   = 16;           // fraction bits
   localparam int KW   = 31;           // coefficient register width
   localparam int DW   = CW + 1;       // separation / velocity difference width
   localparam int QW   = 2 * DW;       // squared length and products
   localparam int LW   = DW;           // integer square root width
   localparam int DOTW = QW + 2;       // signed dot product
   localparam int TW   = 98;           // spring and damper term magnitudes
   localparam int NSW  = TW + 1;       // signed sum of terms
   localparam int NMW  = 3 * DW;       // term magnitude, padded to three chunks
   localparam int NW   = NMW + DW;     // dividend width
   localparam int DENW = QW + FB;      // divisor width: L^2 scaled

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REST      = 2'd2;

   // Saturation limits of a force magnitude
   localparam logic [CW-1:0] LIM_NEG = CW'(1) << (CW - 1);
   localparam logic [CW-1:0] LIM_POS = LIM_NEG - CW'(1);

   typedef struct packed {
      logic signed [CW-1:0] pos_a_x;
      logic signed [CW-1:0] pos_a_y;
      logic signed [CW-1:0] pos_a_z;
      logic signed [CW-1:0] pos_b_x;
      logic signed [CW-1:0] pos_b_y;
      logic signed [CW-1:0] pos_b_z;
      logic signed [CW-1:0] vel_a_x;
      logic signed [CW-1:0] vel_a_y;
      logic signed [CW-1:0] vel_a_z;
      logic signed [CW-1:0] vel_b_x;
      logic signed [CW-1:0] vel_b_y;
      logic signed [CW-1:0] vel_b_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] force_x;
      logic signed [CW-1:0] force_y;
      logic signed [CW-1:0] force_z;
      logic                 degenerate;
      logic                 saturated;
   } rsp_type;

endpackage

// File: rtl/sdf_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on sdf_pkg; carries a side payload alongside each radicand.
module sdf_isqrt #(
   parameter int SW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [sdf_pkg::QW-1:0]  in_rad,
   input  logic [SW-1:0]           in_side,
   output logic                    out_valid,
   output logic [sdf_pkg::LW-1:0]  out_root,
   output logic [SW-1:0]           out_side
);
   import sdf_pkg::*;

   localparam int RW = QW + 1;

   logic          v_ff    [0:LW-1];
   logic [RW-1:0] op_ff   [0:LW-1];
   logic [RW-1:0] res_ff  [0:LW-1];
   logic [SW-1:0] side_ff [0:LW-1];

   // One digit step per stage: test res + bit against the remaining operand
   for (genvar k = 0; k < LW; k++) begin : g_step
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (LW - 1 - k));
      logic          v_prev;
      logic [RW-1:0] op_prev;
      logic [RW-1:0] res_prev;
      logic [SW-1:0] side_prev;
      logic [RW-1:0] trial;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign op_prev   = {1'b0, in_rad};
         assign res_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign op_prev   = op_ff[k-1];
         assign res_prev  = res_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial = res_prev + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
         if (op_prev >= trial) begin
            op_ff[k]  <= op_prev - trial;
            res_ff[k] <= (res_prev >> 1) + BIT;
         end else begin
            op_ff[k]  <= op_prev;
            res_ff[k] <= res_prev >> 1;
         end
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = v_ff[LW-1];
   assign out_root  = res_ff[LW-1][LW-1:0];
   assign out_side  = side_ff[LW-1];

endmodule

// File: rtl/sdf_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Depends on sdf_pkg; carries a side payload alongside each dividend.
module sdf_div #(
   parameter int SW = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [sdf_pkg::NW-1:0]    in_num,
   input  logic [sdf_pkg::DENW-1:0]  in_den,
   input  logic [SW-1:0]             in_side,
   output logic                      out_valid,
   output logic [sdf_pkg::CW-1:0]    out_quo,
   output logic                      out_ovf,
   output logic [SW-1:0]             out_side
);
   import sdf_pkg::*;

   localparam int QB = CW;
   localparam int RW = DENW + QB;

   logic            v_ff    [0:QB];
   logic [RW-1:0]   rem_ff  [0:QB];
   logic [DENW-1:0] den_ff  [0:QB];
   logic [QB-1:0]   quo_ff  [0:QB];
   logic            ovf_ff  [0:QB];
   logic [SW-1:0]   side_ff [0:QB];

   // Entry: quotient needs more than QB bits when num >= den << QB
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      ovf_ff[0]  <= in_num >= NW'({in_den, {QB{1'b0}}});
      rem_ff[0]  <= in_num[RW-1:0];
      den_ff[0]  <= in_den;
      quo_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   // Restoring steps, most significant quotient bit first
   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [RW-1:0] shd;
      assign shd = RW'(den_ff[k-1]) << (QB - k);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_ff[k-1];
         end
         if (rem_ff[k-1] >= shd) begin
            rem_ff[k] <= rem_ff[k-1] - shd;
            quo_ff[k] <= quo_ff[k-1] | (QB'(1) << (QB - k));
         end else begin
            rem_ff[k] <= rem_ff[k-1];
            quo_ff[k] <= quo_ff[k-1];
         end
         den_ff[k]  <= den_ff[k-1];
         ovf_ff[k]  <= ovf_ff[k-1];
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = v_ff[QB];
   assign out_quo   = quo_ff[QB];
   assign out_ovf   = ovf_ff[QB];
   assign out_side  = side_ff[QB];

endmodule

// File: rtl/spring_damper_force_top.sv
// Spring-damper force: fully pipelined, one transaction accepted every cycle.
// A result strobes out once its request has passed through 3 front stages,
// 33 square-root stages, 8 term stages, 33 divider stages and the output register.
// Throughput: one spring per cycle; busy is never raised.
// Reset clears the coefficient registers to zero and empties the pipeline.
module spring_damper_force_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  sdf_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output sdf_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sdf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sdf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sdf_pkg::*;

   localparam int ADW  = DOTW - 1;        // |dot|
   localparam int SPL  = 34;              // split point of |dot|
   localparam int KEW  = KW + LW;         // ks * |ext|
   localparam int KDLW = KW + SPL;
   localparam int KDHW = KW + ADW - SPL;
   localparam int KLW  = 32 + LW;         // half of ke times L
   localparam int SQSW = 3 * DW + DOTW + 1;

   // Coefficient registers
   logic [KW-1:0] ks_ff, kd_ff, rest_ff;

   // Lane views of the request
   logic signed [CW-1:0] pa [3], pb [3], va [3], vb [3];

   // Front stages
   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [DW-1:0] d1_ff [3], dv1_ff [3], d2_ff [3], d3_ff [3];
   logic [QW-1:0]        sq2_ff [3];
   logic signed [QW-1:0] pr2_ff [3];
   logic [QW-1:0]        q3_ff;
   logic signed [DOTW-1:0] dot3_ff;
   logic                 degen3_ff;

   // Square root
   logic                   sq_valid;
   logic [LW-1:0]          sq_root;
   logic [SQSW-1:0]        sq_side;
   logic signed [DW-1:0]   d_s [3];
   logic signed [DOTW-1:0] dot_s;
   logic                   degen_s;
   logic [LW-1:0]          rest_ext;

   // Term stages
   logic v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;
   logic degen4_ff, degen5_ff, degen6_ff, degen7_ff, degen8_ff, degen9_ff;
   logic degen10_ff, degen11_ff;
   logic signed [DW-1:0] d4_ff [3], d5_ff [3], d6_ff [3], d7_ff [3], d8_ff [3];
   logic [LW-1:0]   len4_ff, len5_ff, emag4_ff;
   logic [QW-1:0]   lsq4_ff, lsq5_ff, lsq6_ff, lsq7_ff, lsq8_ff, lsq9_ff, lsq10_ff;
   logic            eneg4_ff, eneg5_ff, eneg6_ff, eneg7_ff;
   logic            dneg4_ff, dneg5_ff, dneg6_ff, dneg7_ff;
   logic [ADW-1:0]  adot4_ff;
   logic [KEW-1:0]  ke5_ff;
   logic [KDLW-1:0] kdl5_ff;
   logic [KDHW-1:0] kdh5_ff;
   logic [KLW-1:0]  kel6_ff, keh6_ff;
   logic [TW-1:0]   tb6_ff, tb7_ff, ta7_ff;
   logic signed [NSW-1:0] sa8, sb8, num8_ff;
   logic [NMW-1:0]  nmag9_ff;
   logic            nneg9_ff;
   logic [DW-1:0]   dmag9_ff [3];
   logic            dsgn9_ff [3];
   logic [QW-1:0]   pp10_ff [3][3];
   logic            lneg10_ff [3], lneg11_ff [3];
   logic [NW-1:0]   n11_ff [3];
   logic [DENW-1:0] den11_ff;

   // Divider outputs
   logic          dv_valid [3];
   logic [CW-1:0] dv_quo [3];
   logic          dv_ovf [3];
   logic [1:0]    dv_side [3];

   // Output stage
   logic [CW-1:0] lim [3], mag [3], frc [3];
   logic          sat [3];
   logic          degen_o;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ff   <= '0;
         kd_ff   <= '0;
         rest_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STIFFNESS: ks_ff   <= csr_wdata[KW-1:0];
            CSR_DAMPING:   kd_ff   <= csr_wdata[KW-1:0];
            CSR_REST:      rest_ff <= csr_wdata[KW-1:0];
            default: ;
         endcase
      end
   end

   assign pa = '{req_data.pos_a_x, req_data.pos_a_y, req_data.pos_a_z};
   assign pb = '{req_data.pos_b_x, req_data.pos_b_y, req_data.pos_b_z};
   assign va = '{req_data.vel_a_x, req_data.vel_a_y, req_data.vel_a_z};
   assign vb = '{req_data.vel_b_x, req_data.vel_b_y, req_data.vel_b_z};

   // Stage 1: separation and velocity difference
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      for (int i = 0; i < 3; i++) begin
         d1_ff[i]  <= DW'(pa[i]) - DW'(pb[i]);
         dv1_ff[i] <= DW'(va[i]) - DW'(vb[i]);
      end
   end

   // Stage 2: per-axis products
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      for (int i = 0; i < 3; i++) begin
         sq2_ff[i] <= QW'(d1_ff[i]) * QW'(d1_ff[i]);
         pr2_ff[i] <= QW'(dv1_ff[i]) * QW'(d1_ff[i]);
         d2_ff[i]  <= d1_ff[i];
      end
   end

   // Stage 3: squared length and dot product
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      q3_ff     <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      dot3_ff   <= DOTW'(pr2_ff[0]) + DOTW'(pr2_ff[1]) + DOTW'(pr2_ff[2]);
      degen3_ff <= (d2_ff[0] == '0) && (d2_ff[1] == '0) && (d2_ff[2] == '0);
      d3_ff     <= d2_ff;
   end

   sdf_isqrt #(.SW(SQSW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_rad    (q3_ff),
      .in_side   ({d3_ff[0], d3_ff[1], d3_ff[2], dot3_ff, degen3_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {d_s[0], d_s[1], d_s[2], dot_s, degen_s} = sq_side;
   assign rest_ext = LW'(rest_ff);

   // Stage 4: extension, L^2 and |dot|
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= sq_valid;
      end
      if (sq_root >= rest_ext) begin
         emag4_ff <= sq_root - rest_ext;
         eneg4_ff <= 1'b0;
      end else begin
         emag4_ff <= rest_ext - sq_root;
         eneg4_ff <= 1'b1;
      end
      lsq4_ff   <= QW'(sq_root) * QW'(sq_root);
      dneg4_ff  <= dot_s[DOTW-1];
      adot4_ff  <= dot_s[DOTW-1] ? ADW'(-dot_s) : ADW'(dot_s);
      len4_ff   <= sq_root;
      d4_ff     <= d_s;
      degen4_ff <= degen_s;
   end

   // Stage 5: ks * |ext| and split kd * |dot|
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      ke5_ff    <= KEW'(ks_ff) * KEW'(emag4_ff);
      kdl5_ff   <= KDLW'(kd_ff) * KDLW'(adot4_ff[SPL-1:0]);
      kdh5_ff   <= KDHW'(kd_ff) * KDHW'(adot4_ff[ADW-1:SPL]);
      len5_ff   <= len4_ff;
      lsq5_ff   <= lsq4_ff;
      eneg5_ff  <= eneg4_ff;
      dneg5_ff  <= dneg4_ff;
      d5_ff     <= d4_ff;
      degen5_ff <= degen4_ff;
   end

   // Stage 6: split (ks * |ext|) * L, combine damper halves
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      kel6_ff   <= KLW'(ke5_ff[31:0]) * KLW'(len5_ff);
      keh6_ff   <= KLW'(ke5_ff[KEW-1:32]) * KLW'(len5_ff);
      tb6_ff    <= TW'(kdl5_ff) + (TW'(kdh5_ff) << SPL);
      lsq6_ff   <= lsq5_ff;
      eneg6_ff  <= eneg5_ff;
      dneg6_ff  <= dneg5_ff;
      d6_ff     <= d5_ff;
      degen6_ff <= degen5_ff;
   end

   // Stage 7: combine spring halves
   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      ta7_ff    <= TW'(kel6_ff) + (TW'(keh6_ff) << 32);
      tb7_ff    <= tb6_ff;
      lsq7_ff   <= lsq6_ff;
      eneg7_ff  <= eneg6_ff;
      dneg7_ff  <= dneg6_ff;
      d7_ff     <= d6_ff;
      degen7_ff <= degen6_ff;
   end

   // Stage 8: signed sum of spring and damper terms
   assign sa8 = eneg7_ff ? -$signed({1'b0, ta7_ff}) : $signed({1'b0, ta7_ff});
   assign sb8 = dneg7_ff ? -$signed({1'b0, tb7_ff}) : $signed({1'b0, tb7_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
      num8_ff   <= sa8 + sb8;
      lsq8_ff   <= lsq7_ff;
      d8_ff     <= d7_ff;
      degen8_ff <= degen7_ff;
   end

   // Stage 9: magnitudes and signs
   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8_ff;
      end
      nneg9_ff <= num8_ff[NSW-1];
      nmag9_ff <= num8_ff[NSW-1] ? NMW'(-num8_ff) : NMW'(num8_ff);
      for (int i = 0; i < 3; i++) begin
         dsgn9_ff[i] <= d8_ff[i][DW-1];
         dmag9_ff[i] <= d8_ff[i][DW-1] ? DW'(-d8_ff[i]) : DW'(d8_ff[i]);
      end
      lsq9_ff   <= lsq8_ff;
      degen9_ff <= degen8_ff;
   end

   // Stage 10: term times |d_i|, three chunk products per lane
   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= v9_ff;
      end
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            pp10_ff[i][k] <= QW'(nmag9_ff[k*DW +: DW]) * QW'(dmag9_ff[i]);
         end
         lneg10_ff[i] <= nneg9_ff ^ dsgn9_ff[i];
      end
      lsq10_ff   <= lsq9_ff;
      degen10_ff <= degen9_ff;
   end

   // Stage 11: sum chunk products, scale the divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else begin
         v11_ff <= v10_ff;
      end
      for (int i = 0; i < 3; i++) begin
         n11_ff[i] <= NW'(pp10_ff[i][0]) + (NW'(pp10_ff[i][1]) << DW)
                      + (NW'(pp10_ff[i][2]) << (2 * DW));
         lneg11_ff[i] <= lneg10_ff[i];
      end
      den11_ff   <= {lsq10_ff, {FB{1'b0}}};
      degen11_ff <= degen10_ff;
   end

   // One divider per axis
   for (genvar i = 0; i < 3; i++) begin : g_lane
      sdf_div #(.SW(2)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v11_ff),
         .in_num    (n11_ff[i]),
         .in_den    (den11_ff),
         .in_side   ({lneg11_ff[i], degen11_ff}),
         .out_valid (dv_valid[i]),
         .out_quo   (dv_quo[i]),
         .out_ovf   (dv_ovf[i]),
         .out_side  (dv_side[i])
      );

      // Clip to the signed range and apply the sign
      assign lim[i] = dv_side[i][1] ? LIM_NEG : LIM_POS;
      assign sat[i] = dv_ovf[i] || (dv_quo[i] > lim[i]);
      assign mag[i] = sat[i] ? lim[i] : dv_quo[i];
      assign frc[i] = dv_side[i][1] ? -mag[i] : mag[i];
   end

   assign degen_o = dv_side[0][0] & dv_side[1][0] & dv_side[2][0];

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid[0] & dv_valid[1] & dv_valid[2];
      end
      if (degen_o) begin
         rsp_ff.force_x    <= '0;
         rsp_ff.force_y    <= '0;
         rsp_ff.force_z    <= '0;
         rsp_ff.degenerate <= 1'b1;
         rsp_ff.saturated  <= 1'b0;
      end else begin
         rsp_ff.force_x    <= frc[0];
         rsp_ff.force_y    <= frc[1];
         rsp_ff.force_z    <= frc[2];
         rsp_ff.degenerate <= 1'b0;
         rsp_ff.saturated  <= sat[0] | sat[1] | sat[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
